// ----- design/set_union_dedup_append_top_defines.svh -----
// Assertion macros used by the top RTL file of the union block.
`ifndef SET_UNION_DEDUP_APPEND_TOP_DEFINES_SVH
`define SET_UNION_DEDUP_APPEND_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SUD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("set union check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SUD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("set union check failed");

`endif

// ----- design/sud_pkg.sv -----
`default_nettype none

package sud_pkg;

    // Store geometry.
    localparam int MAX_ENTRIES = 64;
    localparam int VALUE_BITS  = 32;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Search token that walks down the row of cells.
    typedef struct packed {
        logic                  vld;
        logic [VALUE_BITS-1:0] val;
        logic                  hit;
    } t_tok;

endpackage

`default_nettype wire

// ----- design/sud_cell.sv -----
`default_nettype none

module sud_cell (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_wr_en,
    input  wire logic [sud_pkg::VALUE_BITS-1:0] i_wr_val,
    input  wire logic                           i_active,
    input  wire sud_pkg::t_tok                  i_tok,
    output sud_pkg::t_tok                       o_tok
);

    logic [sud_pkg::VALUE_BITS-1:0] r_entry;
    sud_pkg::t_tok                  r_tok;
    sud_pkg::t_tok                  n_tok;

    // The entry held by this cell is written when the append lands here.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_entry <= i_wr_val;
        end
    end

    // A live cell marks the passing token when its entry matches.
    always_comb begin
        n_tok     = i_tok;
        n_tok.hit = i_tok.hit | (i_active & (r_entry == i_tok.val));
    end

    // Hand the token to the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// ----- design/set_union_dedup_append_top.sv -----
// Streaming union of two integer lists with duplicate removal.
//
// Request channel: an item is taken at a rising edge where start is high
// and busy is low. Each item carries a value, a list select, a flag that
// clears the store before the item, and a flag that marks the last item.
// Result channel: o_strobe is high for one cycle with the result fields;
// there is no back-pressure, so every result must be taken when shown.
// A result appears when the item is appended or when it is the last item.
//
// Request flow: a first-list item is appended without a search; its
// result is registered and shows in the cycle after acceptance, and busy
// stays low, so one such item can be taken every cycle while no search is
// running. A second-list item sends a search token down the row of 64
// compare cells, one cell per cycle; busy is high while the token is in
// the row, and its result is registered once the token leaves the last
// cell, so a new request is taken only after the search is through.
//
// Reset clears the count, the full flag and the search chain; the stored
// entries are not cleared, only entries below the count are compared.
`default_nettype none

`include "set_union_dedup_append_top_defines.svh"

module set_union_dedup_append_top (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic signed [sud_pkg::VALUE_BITS-1:0] i_value_in,
    input  wire logic                                  i_from_second,
    input  wire logic                                  i_first_of_set,
    input  wire logic                                  i_last_item,
    output logic                                       o_strobe,
    output logic signed [sud_pkg::VALUE_BITS-1:0]      o_value_out,
    output logic                                       o_appended,
    output logic [sud_pkg::IDX_W-1:0]                  o_position,
    output logic [sud_pkg::CNT_W-1:0]                  o_union_count,
    output logic                                       o_done_res,
    output logic                                       o_full_res
);

    localparam int MAX = sud_pkg::MAX_ENTRIES;
    localparam int IW  = sud_pkg::IDX_W;
    localparam int CW  = sud_pkg::CNT_W;
    localparam int VW  = sud_pkg::VALUE_BITS;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic          r_state;
    logic [CW-1:0] r_cnt;
    logic          r_ovf;
    logic          r_last;

    logic          w_acc;
    logic          w_clr;
    logic          w_fin;
    logic          w_eval;
    logic [CW-1:0] w_base_cnt;
    logic          w_base_ovf;
    logic          w_want;
    logic [VW-1:0] w_val;
    logic          w_last;
    logic          w_full;
    logic          w_add;
    logic [CW-1:0] n_cnt;
    logic          n_ovf;
    logic          w_emit;

    sud_pkg::t_tok w_tok [0:MAX];

    assign busy  = (r_state == S_SCAN);
    assign w_acc = start & ~busy;
    assign w_clr = w_acc & i_first_of_set;
    assign w_fin = w_tok[MAX].vld;

    // Second-list requests enter the head of the chain as a search token.
    always_comb begin
        w_tok[0].vld = w_acc & i_from_second;
        w_tok[0].val = $unsigned(i_value_in);
        w_tok[0].hit = 1'b0;
    end

    // Row of compare cells; cell k holds store entry k. A request that clears
    // the store sees no live entry in the cycle it is taken.
    genvar k;
    generate
        for (k = 0; k < MAX; k++) begin : g_cell
            sud_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_wr_en  (w_add && (w_base_cnt[IW-1:0] == IW'(k))),
                .i_wr_val (w_val),
                .i_active ((r_cnt > CW'(k)) & ~w_clr),
                .i_tok    (w_tok[k]),
                .o_tok    (w_tok[k+1])
            );
        end
    endgenerate

    // Append decision, shared by direct first-list requests and finished searches.
    always_comb begin
        if (w_fin) begin
            w_base_cnt = r_cnt;
            w_base_ovf = r_ovf;
            w_want     = ~w_tok[MAX].hit;
            w_val      = w_tok[MAX].val;
            w_last     = r_last;
        end else begin
            w_base_cnt = i_first_of_set ? '0 : r_cnt;
            w_base_ovf = i_first_of_set ? 1'b0 : r_ovf;
            w_want     = 1'b1;
            w_val      = $unsigned(i_value_in);
            w_last     = i_last_item;
        end
        w_eval = w_fin | (w_acc & ~i_from_second);
        w_full = (w_base_cnt == CW'(MAX));
        w_add  = w_eval & w_want & ~w_full;
        n_ovf  = w_base_ovf | (w_want & w_full);
        n_cnt  = w_base_cnt + CW'(w_add);
        w_emit = w_eval & (w_add | w_last);
    end

    // Control state: sequencer, count and full flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (w_eval) begin
                r_cnt <= n_cnt;
                r_ovf <= n_ovf;
            end else if (w_acc && i_first_of_set) begin
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc && i_from_second) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_fin) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Remember the last-item flag of the request being searched.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_last <= i_last_item;
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            o_value_out   <= w_add ? $signed(w_val) : '0;
            o_appended    <= w_add;
            o_position    <= w_add ? w_base_cnt[IW-1:0] : '0;
            o_union_count <= n_cnt;
            o_done_res    <= w_last;
            o_full_res    <= n_ovf;
        end
    end

    `SUD_ASSERT_SAME(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(MAX))
    `SUD_ASSERT_SAME(a_emit_cause, i_clk, i_rst_n, o_strobe, o_appended || o_done_res)
    `SUD_ASSERT_SAME(a_pos_count, i_clk, i_rst_n, o_strobe && o_appended,
                     o_union_count == ({1'b0, o_position} + CW'(1)))
    `SUD_ASSERT_SAME(a_tok_scan, i_clk, i_rst_n, w_fin, r_state == S_SCAN)
    `SUD_ASSERT_NEXT(a_search_busy, i_clk, i_rst_n, start && !busy && i_from_second, busy)

endmodule

`default_nettype wire
